// ===== rtl/core/rgbhsv_pkg.sv =====
// rgbhsv_pkg: shared constants, types and functions for the RGB to HSV pipeline.
// Depends on nothing.
`timescale 1ns / 1ps

package rgbhsv_pkg;

	localparam int FRAC_BITS = 16;
	localparam int HUE_W = 16;
	localparam int SB_W = 17;

	// reciprocal table entry: floor(2^RECIP_SH / (k*x)) + 1, x = 1..255
	localparam int RECIP_SH = 30;
	localparam int RECIP_W = 31;

	// sector codes
	typedef enum logic [1:0] {
		SEC_RED   = 2'd0,
		SEC_GREEN = 2'd1,
		SEC_BLUE  = 2'd2
	} sector_t;

	typedef struct packed {
		logic [7:0]  mx;
		logic [7:0]  d;
		logic [10:0] n;   // hue numerator after wrap, 0..6d-1
	} minmax_t;

	// elaboration-time table builder; entry 0 stays zero
	function automatic logic [256*RECIP_W-1:0] build_recip(input int k);
		logic [256*RECIP_W-1:0] t;
		t = '0;
		for (int i = 1; i < 256; i++) begin
			t[i*RECIP_W +: RECIP_W] = RECIP_W'(((64'd1 << RECIP_SH) / 64'(k * i)) + 64'd1);
		end
		return t;
	endfunction

	localparam logic [256*RECIP_W-1:0] RECIP_TBL  = build_recip(1);
	localparam logic [256*RECIP_W-1:0] RECIP6_TBL = build_recip(6);
	localparam logic [RECIP_W-1:0] RECIP_255 =
		RECIP_W'(((64'd1 << RECIP_SH) / 64'd255) + 64'd1);

	// reciprocal of x
	function automatic logic [RECIP_W-1:0] recip(input logic [7:0] x);
		return RECIP_TBL[32'(x) * RECIP_W +: RECIP_W];
	endfunction

	// reciprocal of 6*x
	function automatic logic [RECIP_W-1:0] recip6(input logic [7:0] x);
		return RECIP6_TBL[32'(x) * RECIP_W +: RECIP_W];
	endfunction

endpackage

// ===== rtl/core/rgbhsv_minmax.sv =====
// rgbhsv_minmax: stage 1, channel max/min, range and hue numerator.
// Depends on rgbhsv_pkg.
`timescale 1ns / 1ps

module rgbhsv_minmax (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 vld,
	input  logic [7:0]           red,
	input  logic [7:0]           green,
	input  logic [7:0]           blue,
	output logic                 vld_s1,
	output rgbhsv_pkg::minmax_t  mm_s1
);

	logic [7:0] mx, mn, d;
	logic [11:0] n;
	rgbhsv_pkg::sector_t sec;

	always_comb begin
		mx = (red > green) ? red : green;
		mn = (red < green) ? red : green;
		if (blue > mx) mx = blue;
		if (blue < mn) mn = blue;
		d = mx - mn;
		if (red == mx) sec = rgbhsv_pkg::SEC_RED;
		else if (green == mx) sec = rgbhsv_pkg::SEC_GREEN;
		else sec = rgbhsv_pkg::SEC_BLUE;
		unique case (sec)
			rgbhsv_pkg::SEC_RED:   n = {4'd0, green} - {4'd0, blue};
			rgbhsv_pkg::SEC_GREEN: n = {3'd0, d, 1'b0} + {4'd0, blue} - {4'd0, red};
			default:               n = {2'd0, d, 2'b0} + {4'd0, red} - {4'd0, green};
		endcase
		if (n[11]) n = n + {1'b0, d, 3'b0} - {2'b0, d, 2'b0} + {3'b0, d, 1'b0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else vld_s1 <= vld;
	end

	always_ff @(posedge clk) begin
		mm_s1.mx <= mx;
		mm_s1.d  <= d;
		mm_s1.n  <= n[10:0];
	end

endmodule

// ===== rtl/core/rgbhsv_divround.sv =====
// rgbhsv_divround: rounded num*2^F/den by reciprocal multiply, two stages.
// Stage A: multiply by the caller's reciprocal; stage B: one compare and subtract.
// Depends on rgbhsv_pkg.
`timescale 1ns / 1ps

module rgbhsv_divround (
	input  logic                           clk,
	input  logic [10:0]                    num,
	input  logic [10:0]                    den,
	input  logic [rgbhsv_pkg::RECIP_W-1:0] rcp,
	output logic [17:0]                    quo
);

	// q = floor((2*num*2^F + den) / (2*den)); form N = 2*num*2^F + den
	logic [28:0] nn;
	logic [28:0] nn_s1;
	logic [11:0] d2_s1;
	logic [59:0] prod_s1;
	logic [17:0] qe;
	logic [29:0] rem;

	assign nn = {1'b0, num, 17'd0} + 29'(den);

	always_ff @(posedge clk) begin
		nn_s1   <= nn;
		d2_s1   <= {den, 1'b0};
		prod_s1 <= 60'(nn) * 60'(rcp);
	end

	// estimate may be one high or low; recover exact floor
	always_comb begin
		qe  = 18'(prod_s1 >> (rgbhsv_pkg::RECIP_SH + 1));
		rem = 30'(nn_s1) - 30'(qe) * 30'(d2_s1);
		if (rem[29]) qe = qe - 18'd1;
		else if (rem[28:0] >= 29'(d2_s1)) qe = qe + 18'd1;
	end

	always_ff @(posedge clk) quo <= qe;

endmodule

// ===== rtl/core/rgb_to_hsv_converter.sv =====
// rgb_to_hsv_converter: top level of the pipelined RGB to HSV converter.
// Depends on rgbhsv_pkg, rgbhsv_minmax, rgbhsv_divround.
`timescale 1ns / 1ps

// Usage:
//  A request is one pixel on red/green/blue, taken at a rising edge where
//  start is high; busy is tied low, so a pixel can enter every cycle.
//  Results come out on hue/saturation/brightness with done high for one
//  cycle, in order. Throughput is one pixel per clock; the pipeline runs
//  a min/max stage, a reciprocal multiply stage and a correction stage.
//  Three dividers run side by side: hue over 6*d, saturation over max,
//  brightness over 255; hue and saturation each use a 256-entry reciprocal
//  table multiply, brightness a constant reciprocal, each plus one fixup.
//  The receiver cannot stall, so no backpressure exists.
//  Reset (arst_n low) clears the valid pipe; in-flight pixels are dropped.
//  Grey pixels give hue 0, black pixels saturation 0, and a hue that rounds
//  to a full turn wraps to 0.
module rgb_to_hsv_converter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [7:0]  red,
	input  logic [7:0]  green,
	input  logic [7:0]  blue,
	output logic        done,
	output logic [15:0] hue,
	output logic [16:0] saturation,
	output logic [16:0] brightness
);

	logic                vld_s1;
	rgbhsv_pkg::minmax_t mm_s1;
	logic [1:0]          vld_q;
	logic [7:0]          mx_s2, mx_s3;
	logic [7:0]          d_s2, d_s3;
	logic [17:0]         hq, sq, bq;
	logic [10:0]         six_d;
	logic [rgbhsv_pkg::RECIP_W-1:0] hue_rcp, sat_rcp;

	assign busy = 1'b0;

	rgbhsv_minmax u_mm (
		.clk(clk), .arst_n(arst_n), .vld(start),
		.red(red), .green(green), .blue(blue),
		.vld_s1(vld_s1), .mm_s1(mm_s1)
	);

	assign six_d = {1'b0, mm_s1.d, 2'b0} + {2'b0, mm_s1.d, 1'b0};

	// reciprocals indexed by the 8-bit range and max
	assign hue_rcp = rgbhsv_pkg::recip6(mm_s1.d);
	assign sat_rcp = rgbhsv_pkg::recip(mm_s1.mx);

	// dividers; zero divisors give garbage masked below
	rgbhsv_divround u_hue (.clk(clk), .num(mm_s1.n), .den(six_d), .rcp(hue_rcp),
		.quo(hq));
	rgbhsv_divround u_sat (.clk(clk), .num({3'd0, mm_s1.d}),
		.den({3'd0, mm_s1.mx}), .rcp(sat_rcp), .quo(sq));
	rgbhsv_divround u_bri (.clk(clk), .num({3'd0, mm_s1.mx}),
		.den(11'd255), .rcp(rgbhsv_pkg::RECIP_255), .quo(bq));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[0], vld_s1};
		end
	end

	// strobe lines up with the divider output registers
	assign done = vld_q[1];

	always_ff @(posedge clk) begin
		mx_s2 <= mm_s1.mx;
		d_s2  <= mm_s1.d;
		mx_s3 <= mx_s2;
		d_s3  <= d_s2;
	end

	// mask special cases as divider results land
	assign hue = (d_s3 == 8'd0 || hq[16]) ? 16'd0 : hq[15:0];
	assign saturation = (mx_s3 == 8'd0) ? 17'd0 : sq[16:0];
	assign brightness = bq[16:0];

endmodule

// ===== sim/tb.sv =====
// tb: self-checking testbench for rgb_to_hsv_converter.
// Depends on rgbhsv_pkg and the rgb_to_hsv_converter RTL; drives pixels, checks HSV results.
`timescale 1ns / 1ps

// Scoreboard: predicts hue/saturation/brightness per accepted pixel and
// checks strobed results against the oldest prediction in order.
class hsv_scoreboard;
	typedef struct {
		logic [15:0] hue;
		logic [16:0] sat;
		logic [16:0] bri;
	} hsv_t;

	hsv_t pending[$];
	bit   failed;

	// round num/den to nearest, halves up
	static function longint unsigned div_near(longint unsigned num, longint unsigned den);
		return (2 * num + den) / (2 * den);
	endfunction

	function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
		hsv_t e;
		int unsigned mx, mn, dlt;
		int n;
		longint unsigned one, h;
		one = 64'd1 << rgbhsv_pkg::FRAC_BITS;
		mx = r > g ? r : g;
		mn = r < g ? r : g;
		if (b > mx) mx = b;
		if (b < mn) mn = b;
		dlt = mx - mn;
		e.bri = 17'(div_near(mx * one, 255));
		e.sat = (mx != 0) ? 17'(div_near(dlt * one, mx)) : '0;
		h = 0;
		if (dlt != 0) begin
			// red wins ties, then green
			if (r == mx) n = int'(g) - int'(b);
			else if (g == mx) n = 2 * int'(dlt) + int'(b) - int'(r);
			else n = 4 * int'(dlt) + int'(r) - int'(g);
			if (n < 0) n += 6 * int'(dlt);
			h = div_near(longint'(n) * one, 6 * dlt);
			if (h >= one) h = 0;  // full turn wraps
		end
		e.hue = 16'(h);
		pending = {pending, e};
	endfunction

	function void check_result(logic [15:0] h, logic [16:0] s, logic [16:0] v);
		hsv_t e;
		if (pending.size() == 0) begin
			$display("%0t: unexpected result hue=%0d sat=%0d bri=%0d", $time, h, s, v);
			failed = 1;
			return;
		end
		e = pending.pop_front();
		if (h !== e.hue) begin
			$display("%0t: hue expected %0d actual %0d", $time, e.hue, h);
			failed = 1;
		end
		if (s !== e.sat) begin
			$display("%0t: saturation expected %0d actual %0d", $time, e.sat, s);
			failed = 1;
		end
		if (v !== e.bri) begin
			$display("%0t: brightness expected %0d actual %0d", $time, e.bri, v);
			failed = 1;
		end
	endfunction
endclass

module tb;
	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [7:0]  red, green, blue;
	logic        done;
	logic [15:0] hue;
	logic [16:0] saturation, brightness;

	hsv_scoreboard sb;

	rgb_to_hsv_converter u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.red       (red),
		.green     (green),
		.blue      (blue),
		.done      (done),
		.hue       (hue),
		.saturation(saturation),
		.brightness(brightness)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// results cannot be held off: check every strobe at the rising edge
	always @(posedge clk) begin
		if (arst_n && done) sb.check_result(hue, saturation, brightness);
	end

	// present one pixel and hold it until the request is taken
	task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
		int gap;
		gap = $urandom_range(0, 4);
		// random idle before the request; nearly half of pixels go back to back
		if ($urandom_range(0, 2) != 0 && gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		red   <= r;
		green <= g;
		blue  <= b;
		forever begin
			@(posedge clk);
			if (!busy) break;
		end
		sb.note_pixel(r, g, b);
		@(negedge clk);
	endtask

	// random pixel with a bias toward ties, greys and extremes
	task automatic send_random();
		logic [7:0] c[3];
		int kind;
		kind = $urandom_range(0, 9);
		foreach (c[i]) c[i] = 8'($urandom_range(0, 255));
		case (kind)
			0: begin
				c[1] = c[0];
				c[2] = c[0];
			end
			1: c[$urandom_range(0, 2)] = c[$urandom_range(0, 2)];
			2: foreach (c[i]) if ($urandom_range(0, 1)) c[i] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
			3: c[2] = c[0] + 8'($urandom_range(0, 2)) - 8'd1;  // near ties
			default: ;
		endcase
		send_pixel(c[0], c[1], c[2]);
	endtask

	initial begin
		int waited;
		sb     = new();
		arst_n = 1'b0;
		start  = 1'b0;
		red    = '0;
		green  = '0;
		blue   = '0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: black, white, greys, primaries, secondaries, ties and negative hue wrap
		send_pixel(8'd0, 8'd0, 8'd0);
		send_pixel(8'd255, 8'd255, 8'd255);
		send_pixel(8'd128, 8'd128, 8'd128);
		send_pixel(8'd1, 8'd1, 8'd1);
		send_pixel(8'd255, 8'd0, 8'd0);
		send_pixel(8'd0, 8'd255, 8'd0);
		send_pixel(8'd0, 8'd0, 8'd255);
		send_pixel(8'd255, 8'd255, 8'd0);
		send_pixel(8'd0, 8'd255, 8'd255);
		send_pixel(8'd255, 8'd0, 8'd255);
		send_pixel(8'd200, 8'd200, 8'd10);
		send_pixel(8'd10, 8'd200, 8'd200);
		send_pixel(8'd200, 8'd10, 8'd200);
		send_pixel(8'd255, 8'd0, 8'd1);
		send_pixel(8'd255, 8'd254, 8'd255);
		send_pixel(8'd1, 8'd0, 8'd0);
		send_pixel(8'd0, 8'd0, 8'd1);
		send_pixel(8'd170, 8'd85, 8'd0);
		send_pixel(8'd85, 8'd170, 8'd255);

		repeat (1300) send_random();
		start <= 1'b0;

		// wait for the pipe to drain, then a short margin
		waited = 0;
		while (sb.pending.size() != 0 && waited < 1000) begin
			@(negedge clk);
			waited++;
		end
		repeat (8) @(negedge clk);
		if (!sb.failed && sb.pending.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	// watchdog
	initial begin
		#2ms;
		$display("CHECK FAILED");
		$finish;
	end
endmodule
